/* design/uvdc_pkg.sv */
package uvdc_pkg;

  // Input component width (two's complement Q8.8)
  localparam int CW     = 16;
  localparam int MAG_W  = CW;              // |c| fits unsigned, most negative included
  localparam int SQ_W   = 2 * CW - 1;      // |c|^2
  localparam int SUM_W  = 2 * CW;          // sum of three squares
  localparam int MSB_W  = $clog2(SUM_W);
  localparam int T_W    = 64;              // normalized radicand
  localparam int LZ_W   = 7;
  localparam int K_W    = 5;               // half of the normalizing shift
  localparam int K_MAX  = 31;
  localparam int R_W    = 32;              // square root width
  localparam int FRAC   = 14;              // Q1.14 fraction bits
  localparam int Q_W    = FRAC + 1;        // quotient magnitude bits
  localparam int UW     = 16;              // unit component / result width
  localparam int NUM_W  = MAG_W + K_MAX;
  localparam int DIV_W  = NUM_W + FRAC + 1;
  localparam int P_W    = 2 * UW;          // product of two unit components
  localparam int S_W    = P_W + 2;         // sum of up to three products
  localparam int Q14_ONE = 16384;

  typedef logic [2:0][CW-1:0] vec_t;
  typedef logic [2:0][UW-1:0] uvec_t;

  // What travels beside the radicand of one vector
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [K_W-1:0]        k;
    logic                  zero;
  } vside_t;

endpackage

/* design/uvdc_sumsq.sv */
module uvdc_sumsq (
  input  logic             clk,
  input  logic             ce,
  input  uvdc_pkg::vec_t   c,
  output logic [63:0]      t,
  output uvdc_pkg::vside_t side
);
  import uvdc_pkg::*;

  logic [2:0][MAG_W-1:0] mag1, mag2;
  logic [2:0]            neg1, neg2;
  logic [2:0][SQ_W-1:0]  sq1;
  logic [SUM_W-1:0]      sum2;
  logic [2:0][MAG_W-1:0] mag_c;
  logic [MSB_W-1:0]      msb;
  logic [LZ_W-1:0]       lz;
  logic [K_W-1:0]        k_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = c[i][CW-1] ? MAG_W'(-c[i]) : MAG_W'(c[i]);
    end
  end

  // Stage 1: magnitudes and squares
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= mag_c[i];
        neg1[i] <= c[i][CW-1];
        sq1[i]  <= SQ_W'({{MAG_W{1'b0}}, mag_c[i]} * {{MAG_W{1'b0}}, mag_c[i]});
      end
    end
  end

  // Stage 2: sum of squares
  always_ff @(posedge clk) begin
    if (ce) begin
      mag2 <= mag1;
      neg2 <= neg1;
      sum2 <= SUM_W'(sq1[0]) + SUM_W'(sq1[1]) + SUM_W'(sq1[2]);
    end
  end

  // Stage 3: shift by an even count until one of the two top bits is set
  always_comb begin
    msb = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (sum2[i]) msb = MSB_W'(i);
    end
    lz  = LZ_W'(T_W - 1) - LZ_W'(msb);
    k_c = lz[K_W:1];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t         <= T_W'(sum2) << {k_c, 1'b0};
      side.mag  <= mag2;
      side.neg  <= neg2;
      side.k    <= k_c;
      side.zero <= (sum2 == '0);
    end
  end

endmodule

/* design/uvdc_sqrt.sv */
module uvdc_sqrt (
  input  logic             clk,
  input  logic             ce,
  input  logic [63:0]      t_in,
  input  uvdc_pkg::vside_t side_in,
  output logic [31:0]      root,
  output uvdc_pkg::vside_t side_out
);
  import uvdc_pkg::*;

  logic [T_W-1:0] n_st [0:R_W];
  logic [T_W-1:0] r_st [0:R_W];
  vside_t         sd_st [0:R_W];

  assign n_st[0]  = t_in;
  assign r_st[0]  = '0;
  assign sd_st[0] = side_in;

  // One result bit per stage
  for (genvar g = 0; g < R_W; g++) begin : g_step
    localparam logic [T_W-1:0] BIT = T_W'(1) << (T_W - 2 - 2 * g);
    logic [T_W-1:0] trial;
    logic           ge;
    assign trial = r_st[g] + BIT;
    assign ge    = (n_st[g] >= trial);
    always_ff @(posedge clk) begin
      if (ce) begin
        n_st[g+1]  <= ge ? n_st[g] - trial : n_st[g];
        r_st[g+1]  <= ge ? (r_st[g] >> 1) + BIT : r_st[g] >> 1;
        sd_st[g+1] <= sd_st[g];
      end
    end
  end

  assign root     = r_st[R_W][R_W-1:0];
  assign side_out = sd_st[R_W];

endmodule

/* design/uvdc_div.sv */
module uvdc_div (
  input  logic             clk,
  input  logic             ce,
  input  logic [31:0]      root,
  input  uvdc_pkg::vside_t side,
  output uvdc_pkg::uvec_t  u,
  output logic             zero
);
  import uvdc_pkg::*;

  logic [2:0][DIV_W-1:0] rem_st [0:Q_W];
  logic [2:0][Q_W-1:0]   q_st   [0:Q_W];
  logic [R_W-1:0]        m_st   [0:Q_W];
  logic [2:0]            neg_st [0:Q_W];
  logic                  z_st   [0:Q_W];
  logic [2:0][Q_W-1:0]   qc;

  // Prep: dividend = (|c| << k << 14) + m/2
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        rem_st[0][i] <= (DIV_W'(NUM_W'(side.mag[i]) << side.k) << FRAC)
                        + DIV_W'(root >> 1);
      end
      q_st[0]   <= '0;
      m_st[0]   <= root;
      neg_st[0] <= side.neg;
      z_st[0]   <= side.zero;
    end
  end

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar g = 0; g < Q_W; g++) begin : g_step
    localparam int J = Q_W - 1 - g;
    logic [DIV_W-1:0] sub;
    assign sub = DIV_W'(m_st[g]) << J;
    always_ff @(posedge clk) begin
      if (ce) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_st[g][i] >= sub) begin
            rem_st[g+1][i] <= rem_st[g][i] - sub;
            q_st[g+1][i]   <= q_st[g][i] | (Q_W'(1) << J);
          end else begin
            rem_st[g+1][i] <= rem_st[g][i];
            q_st[g+1][i]   <= q_st[g][i];
          end
        end
        m_st[g+1]   <= m_st[g];
        neg_st[g+1] <= neg_st[g];
        z_st[g+1]   <= z_st[g];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (q_st[Q_W][i] > Q_W'(Q14_ONE)) ? Q_W'(Q14_ONE) : q_st[Q_W][i];
    end
  end

  // Apply sign; a zero-length vector gives the zero vector
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (z_st[Q_W]) u[i] <= '0;
        else if (neg_st[Q_W][i]) u[i] <= -UW'(qc[i]);
        else u[i] <= UW'(qc[i]);
      end
      zero <= z_st[Q_W];
    end
  end

endmodule

/* design/uvdc_prod.sv */
module uvdc_prod (
  input  logic            clk,
  input  logic            ce,
  input  uvdc_pkg::uvec_t ua,
  input  uvdc_pkg::uvec_t ub,
  input  logic            zero_in,
  output uvdc_pkg::uvec_t xprod,
  output logic [15:0]     cosine,
  output logic            zero_out
);
  import uvdc_pkg::*;

  logic signed [P_W-1:0] p [0:8];
  logic signed [S_W-1:0] s [0:3];
  logic signed [S_W-1:0] r [0:3];
  logic [UW-1:0]         o [0:3];
  logic                  z1, z2;

  // Stage 1: nine products
  always_ff @(posedge clk) begin
    if (ce) begin
      p[0] <= $signed(ua[0]) * $signed(ub[0]);
      p[1] <= $signed(ua[1]) * $signed(ub[1]);
      p[2] <= $signed(ua[2]) * $signed(ub[2]);
      p[3] <= $signed(ua[1]) * $signed(ub[2]);
      p[4] <= $signed(ua[2]) * $signed(ub[1]);
      p[5] <= $signed(ua[2]) * $signed(ub[0]);
      p[6] <= $signed(ua[0]) * $signed(ub[2]);
      p[7] <= $signed(ua[0]) * $signed(ub[1]);
      p[8] <= $signed(ua[1]) * $signed(ub[0]);
      z1   <= zero_in;
    end
  end

  // Stage 2: dot sum and cross differences
  always_ff @(posedge clk) begin
    if (ce) begin
      s[0] <= S_W'(p[0]) + S_W'(p[1]) + S_W'(p[2]);
      s[1] <= S_W'(p[3]) - S_W'(p[4]);
      s[2] <= S_W'(p[5]) - S_W'(p[6]);
      s[3] <= S_W'(p[7]) - S_W'(p[8]);
      z2   <= z1;
    end
  end

  // Stage 3: round half up to Q1.14 and clamp to +-1
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r[i] = (s[i] + S_W'(1 << (FRAC - 1))) >>> FRAC;
      if (r[i] > S_W'(Q14_ONE)) o[i] = UW'(Q14_ONE);
      else if (r[i] < -S_W'(Q14_ONE)) o[i] = -UW'(Q14_ONE);
      else o[i] = r[i][UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cosine   <= o[0];
      xprod[0] <= o[1];
      xprod[1] <= o[2];
      xprod[2] <= o[3];
      zero_out <= z2;
    end
  end

endmodule

/* design/unit_vector_dot_cross.sv */
// Normalized 3D dot and cross product.
// Input stream (s_*): one word carries two vectors a and b, Q8.8 components.
// Output stream (m_*): one word per input word, in order: the cosine of the
// angle between a and b and the cross product of the unit vectors, Q1.14,
// clamped to +-1. tuser flags that either vector had zero length; the
// results are then zero.
// Pipeline: 55 register stages: 3 for squares and the normalizing shift, 32
// for the square root (one stage per root bit), 17 for the divisions
// (dividend setup, one stage for each of the 15 quotient bits, sign), 3 for
// products, sums and rounding.
// Throughput: one word per cycle while the receiver takes every word.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready low;
// s_tready drops in that case, nothing is dropped or repeated.
// Reset (rst, synchronous): clears all valid bits; no result is pending.
module unit_vector_dot_cross (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z (16 bits each)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // cosine, cross_x, cross_y, cross_z (16 bits each)
  output logic        m_tuser    // zero_length
);
  import uvdc_pkg::*;

  localparam int LAT = 55;

  logic           ce;
  logic [LAT-1:0] vld;
  vec_t           va, vb;
  logic [T_W-1:0] ta, tb;
  vside_t         sa0, sb0, sa1, sb1;
  logic [R_W-1:0] ma, mb;
  uvec_t          ua, ub, cr;
  logic           za, zb;
  logic [UW-1:0]  cosine;

  // Advance everything unless a finished word is held
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  assign va = s_tdata[3*CW-1:0];
  assign vb = s_tdata[6*CW-1:3*CW];

  uvdc_sumsq u_sumsq_a (.clk, .ce, .c(va), .t(ta), .side(sa0));
  uvdc_sumsq u_sumsq_b (.clk, .ce, .c(vb), .t(tb), .side(sb0));

  uvdc_sqrt u_sqrt_a (.clk, .ce, .t_in(ta), .side_in(sa0), .root(ma), .side_out(sa1));
  uvdc_sqrt u_sqrt_b (.clk, .ce, .t_in(tb), .side_in(sb0), .root(mb), .side_out(sb1));

  uvdc_div u_div_a (.clk, .ce, .root(ma), .side(sa1), .u(ua), .zero(za));
  uvdc_div u_div_b (.clk, .ce, .root(mb), .side(sb1), .u(ub), .zero(zb));

  uvdc_prod u_prod (
    .clk, .ce, .ua, .ub,
    .zero_in(za || zb),
    .xprod(cr),
    .cosine,
    .zero_out(m_tuser)
  );

  assign m_tdata = {cr[2], cr[1], cr[0], cosine};

  // A zero-length vector yields all-zero products
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("zero-length word with nonzero result");

  // Cosine and cross_x stay within +-1 in Q1.14
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[15:0]) <= 16'sd16384 &&
                 $signed(m_tdata[15:0]) >= -16'sd16384 &&
                 $signed(m_tdata[31:16]) <= 16'sd16384 &&
                 $signed(m_tdata[31:16]) >= -16'sd16384)
    else $error("result out of range");

  // Root of a nonzero normalized radicand has its top bit set
  a_root_norm: assert property (@(posedge clk) disable iff (rst)
    vld[34] && !sa1.zero |-> ma[R_W-1])
    else $error("square root not normalized");

  // Nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uvdc_pkg::*;

  localparam int LATENCY  = 55;
  localparam int IDLE_PCT = 29;
  localparam int WD_LIMIT = 4000;

  typedef struct packed {
    logic signed [15:0] cosine;
    logic signed [15:0] cross_x;
    logic signed [15:0] cross_y;
    logic signed [15:0] cross_z;
    logic               zero_length;
  } angle_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z (16 bits each)
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // cosine, cross_x, cross_y, cross_z (16 bits each)
  logic        m_tuser;   // zero_length

  unit_vector_dot_cross dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  angle_t pending_angles[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     sink_idles = 1'b1;   // receiver random stalls on/off
  bit     src_idles = 1'b1;    // sender random gaps on/off
  bit     hold_sink = 1'b0;    // long receiver hold-off request

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Integer square root, floor, bit by bit.
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Scale one vector to unit length in Q1.14; returns 1 for a zero vector.
  function automatic bit to_unit(input logic signed [15:0] v[3],
                                 output longint u[3]);
    logic [63:0] sum, t, m, mag, q;
    int k;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? 64'(-longint'(v[i])) : 64'(longint'(v[i]));
      sum += mag * mag;
    end
    if (sum == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    t = sum;
    k = 0;
    while (t[63:62] == 2'b00) begin
      t = t << 2;
      k++;
    end
    m = floor_sqrt(t);
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? 64'(-longint'(v[i])) : 64'(longint'(v[i]));
      q = (((mag << k) << 14) + (m >> 1)) / m;
      if (q > Q14_ONE) q = Q14_ONE;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  // Q2.28 to Q1.14: add half, floor, clamp to +-1.
  function automatic logic signed [15:0] to_q14(longint p);
    longint r;
    r = (p + 8192) >>> 14;
    if (r > Q14_ONE) r = Q14_ONE;
    if (r < -Q14_ONE) r = -Q14_ONE;
    return 16'(r);
  endfunction

  function automatic angle_t predict_angle(logic [95:0] word);
    logic signed [15:0] a[3], b[3];
    longint ua[3], ub[3];
    bit za, zb;
    angle_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = word[16*i +: 16];
      b[i] = word[48 + 16*i +: 16];
    end
    za = to_unit(a, ua);
    zb = to_unit(b, ub);
    res.cosine  = to_q14(ua[0]*ub[0] + ua[1]*ub[1] + ua[2]*ub[2]);
    res.cross_x = to_q14(ua[1]*ub[2] - ua[2]*ub[1]);
    res.cross_y = to_q14(ua[2]*ub[0] - ua[0]*ub[2]);
    res.cross_z = to_q14(ua[0]*ub[1] - ua[1]*ub[0]);
    res.zero_length = za | zb;
    return res;
  endfunction

  // Offer one word, hold it until accepted, queue its prediction.
  // Valid stays high into the next call; drop it only for an idle gap.
  task automatic send_vectors(logic [15:0] ax, ay, az, bx, by, bz);
    logic [95:0] word;
    word = {bz, by, bx, az, ay, ax};
    while (src_idles && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    pending_angles.push_back(predict_angle(word));
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 6)) - 3);
      3: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_vectors(0, 0, 0, 0, 0, 0);
    send_vectors(0, 0, 0, 16'h0100, 0, 0);
    send_vectors(16'h0100, 16'h0100, 16'h0100, 0, 0, 0);
    send_vectors(16'h0100, 0, 0, 16'h0100, 0, 0);
    send_vectors(16'h0100, 0, 0, 0, 16'h0100, 0);
    send_vectors(0, 16'h0100, 0, 0, 0, 16'h0100);
    send_vectors(0, 0, 16'h0100, 16'h0100, 0, 0);
    send_vectors(16'h0100, 0, 0, 16'hff00, 0, 0);
    send_vectors(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_vectors(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_vectors(16'h8000, 0, 0, 0, 16'h7fff, 0);
    send_vectors(1, 0, 0, 0, 0, 1);
    send_vectors(16'hffff, 16'hffff, 16'hffff, 1, 1, 1);
    send_vectors(16'h7fff, 1, 0, 1, 16'h7fff, 0);
    send_vectors(16'h5555, 16'haaaa, 16'h3333, 16'hcccc, 16'h0f0f, 16'hf0f0);
    send_vectors(3, 4, 0, 4, 3, 0);
    send_vectors(16'h8000, 16'h7fff, 1, 16'hffff, 0, 16'h8000);
  endtask

  task automatic test_random(int count);
    repeat (count)
      send_vectors(rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp());
  endtask

  // Back-to-back with no gaps on either side.
  task automatic test_full_rate(int count);
    src_idles = 1'b0;
    sink_idles = 1'b0;
    test_random(count);
    src_idles = 1'b1;
    sink_idles = 1'b1;
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure(int count);
    src_idles = 1'b0;
    hold_sink = 1'b1;
    test_random(count);
    hold_sink = 1'b0;
    src_idles = 1'b1;
  endtask

  // Receiver ready: drive at falling edges; random stalls or one long hold-off
  // per request.
  initial begin
    int hold_left;
    m_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_sink && hold_left == 0) begin
        hold_left = 3 * LATENCY;
        hold_sink = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(sink_idles && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    angle_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48], m_tuser};
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", got);
      end else begin
        want = pending_angles.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: cos %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d zl %b/%b",
                     want.cosine, got.cosine, want.cross_x, got.cross_x,
                     want.cross_y, got.cross_y, want.cross_z, got.cross_z,
                     want.zero_length, got.zero_length);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int drain;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500);
    test_backpressure(150);
    test_full_rate(200);
    test_random(400);
    s_tvalid <= 1'b0;
    drain = 0;
    while (pending_angles.size() != 0 && drain < WD_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/uvdc_pkg.sv
design/uvdc_sumsq.sv
design/uvdc_sqrt.sv
design/uvdc_div.sv
design/uvdc_prod.sv
design/unit_vector_dot_cross.sv
tb/tb_top.sv
